[rtl/core/car_pkg.sv]
// Shared types, constants and arithmetic helpers for the comb/allpass reverb core.
package car_pkg;

    // Default delay line lengths
    localparam int COMB_LEN_A_DEF    = 1116;
    localparam int COMB_LEN_B_DEF    = 1188;
    localparam int COMB_LEN_C_DEF    = 1277;
    localparam int COMB_LEN_D_DEF    = 1356;
    localparam int ALLPASS_LEN_A_DEF = 556;
    localparam int ALLPASS_LEN_B_DEF = 441;

    localparam int SMP_W  = 24;
    localparam int COEF_W = 16;

    // Register reset values (Q1.15)
    localparam logic [COEF_W-1:0] GAIN_RST = 16'd492;
    localparam logic [COEF_W-1:0] ROOM_RST = 16'd16384;
    localparam logic [COEF_W-1:0] WET_RST  = 16'd16384;
    // damping 16384 -> d1 = floor(16384 * 2 / 5), d2 = 32768 - d1
    localparam logic [14:0]       D1_RST   = 15'd6553;
    localparam logic [15:0]       D2_RST   = 16'd26215;
    localparam logic [15:0]       UNITY    = 16'd32768;
    // reciprocal of 5 scaled by 2^18, exact for 17-bit operands
    localparam logic [16:0]       RECIP5   = 17'd52429;

    typedef enum logic [1:0] {
        CFG_GAIN = 2'd0,
        CFG_ROOM = 2'd1,
        CFG_DAMP = 2'd2,
        CFG_WET  = 2'd3
    } t_cfg_idx;

    // Multiplier operand selection
    typedef enum logic [2:0] {
        MOP_NONE,
        MOP_X_GAIN,
        MOP_Y_D2,
        MOP_LP_D1,
        MOP_LP_ROOM,
        MOP_O_WET
    } t_mop;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_GAIN,
        ST_SCALE,
        ST_C_MUL,
        ST_C_MAC,
        ST_C_LP,
        ST_C_FB,
        ST_C_WR,
        ST_AP,
        ST_WET,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic       clr;
        logic       load;
        logic       rd;
        t_mop       mop;
        logic       scale_ld;
        logic       lp_ld;
        logic       comb_wr;
        logic [1:0] comb_sel;
        logic       ap_wr;
        logic       ap_sel;
        logic       out_ld;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_done;
        logic out_free;
    } t_dp_sts;

    // Round half up of a Q15-scaled value: floor((p + 2^14) / 2^15)
    function automatic logic signed [31:0] rnd15(input logic signed [46:0] p);
        logic signed [46:0] r;
        r = p + 47'sd16384;
        return 32'(r >>> 15);
    endfunction

    // Saturate to signed 24 bits
    function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
        if (v > 32'sd8388607) begin
            return 24'sh7FFFFF;
        end else if (v < -32'sd8388608) begin
            return 24'sh800000;
        end
        return v[23:0];
    endfunction

endpackage

[rtl/core/car_in_if.sv]
// Input stream channel: one audio sample word with its last-of-block flag.
interface car_in_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] sample_in;
    logic               block_last_in;

    modport source (output valid, sample_in, block_last_in, input ready);
    modport sink   (input valid, sample_in, block_last_in, output ready);
endinterface

[rtl/core/car_out_if.sv]
// Output stream channel: one reverberated sample word with its last-of-block flag.
interface car_out_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] sample_out;
    logic               block_last_out;

    modport source (output valid, sample_out, block_last_out, input ready);
    modport sink   (input valid, sample_out, block_last_out, output ready);
endinterface

[rtl/core/comb_allpass_reverb_core.sv]
// Top level of the four-comb, two-allpass reverb core.
// One word at a time: a new input word is taken only after the previous one has been loaded
//   into the output register, since the sequencer runs the shared multiplier sequence (five
//   steps per comb filter) for each word; a stalled output word holds the sequencer.
// Reset: synchronous, active low; afterwards all delay lines are zeroed by a
//   clearing pass over the longest line (1356 words by default) before input is taken.
module comb_allpass_reverb_core
    import car_pkg::*;
#(
    parameter int COMB_LEN_A    = COMB_LEN_A_DEF,
    parameter int COMB_LEN_B    = COMB_LEN_B_DEF,
    parameter int COMB_LEN_C    = COMB_LEN_C_DEF,
    parameter int COMB_LEN_D    = COMB_LEN_D_DEF,
    parameter int ALLPASS_LEN_A = ALLPASS_LEN_A_DEF,
    parameter int ALLPASS_LEN_B = ALLPASS_LEN_B_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    car_in_if.sink      i_in,
    car_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    car_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    car_dp #(
        .COMB_LEN_A    (COMB_LEN_A),
        .COMB_LEN_B    (COMB_LEN_B),
        .COMB_LEN_C    (COMB_LEN_C),
        .COMB_LEN_D    (COMB_LEN_D),
        .ALLPASS_LEN_A (ALLPASS_LEN_A),
        .ALLPASS_LEN_B (ALLPASS_LEN_B)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_sample    (i_in.sample_in),
        .i_last      (i_in.block_last_in),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_sample    (o_out.sample_out),
        .o_last      (o_out.block_last_out)
    );

endmodule

[rtl/core/car_ctrl.sv]
// Sequencer that steps the reverb datapath through one sample word.
module car_ctrl
    import car_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state     r_state, n_state;
    logic [1:0] r_k, n_k;
    logic       r_j, n_j;

    // State and loop counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_k     <= '0;
            r_j     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_j     <= n_j;
        end
    end

    // Next state and commands
    always_comb begin
        n_state        = r_state;
        n_k            = r_k;
        n_j            = r_j;
        o_in_ready     = 1'b0;
        o_cmd          = '0;
        o_cmd.mop      = MOP_NONE;
        o_cmd.comb_sel = r_k;
        o_cmd.ap_sel   = r_j;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    o_cmd.rd   = 1'b1;
                    n_state    = ST_GAIN;
                end
            end
            ST_GAIN: begin
                o_cmd.mop = MOP_X_GAIN;
                n_state   = ST_SCALE;
            end
            ST_SCALE: begin
                o_cmd.scale_ld = 1'b1;
                n_k            = '0;
                n_state        = ST_C_MUL;
            end
            ST_C_MUL: begin
                o_cmd.mop = MOP_Y_D2;
                n_state   = ST_C_MAC;
            end
            ST_C_MAC: begin
                o_cmd.mop = MOP_LP_D1;
                n_state   = ST_C_LP;
            end
            ST_C_LP: begin
                o_cmd.lp_ld = 1'b1;
                n_state     = ST_C_FB;
            end
            ST_C_FB: begin
                o_cmd.mop = MOP_LP_ROOM;
                n_state   = ST_C_WR;
            end
            ST_C_WR: begin
                o_cmd.comb_wr = 1'b1;
                n_k           = r_k + 2'd1;
                if (r_k == 2'd3) begin
                    n_j     = 1'b0;
                    n_state = ST_AP;
                end else begin
                    n_state = ST_C_MUL;
                end
            end
            ST_AP: begin
                o_cmd.ap_wr = 1'b1;
                n_j         = 1'b1;
                if (r_j) begin
                    n_state = ST_WET;
                end
            end
            ST_WET: begin
                o_cmd.mop = MOP_O_WET;
                n_state   = ST_OUT;
            end
            ST_OUT: begin
                // hold until the output register can take the word
                if (i_sts.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

endmodule

[rtl/core/car_dp.sv]
// Reverb datapath: delay line memories, lowpass stores, shared multiplier, output register.
module car_dp
    import car_pkg::*;
#(
    parameter int COMB_LEN_A    = COMB_LEN_A_DEF,
    parameter int COMB_LEN_B    = COMB_LEN_B_DEF,
    parameter int COMB_LEN_C    = COMB_LEN_C_DEF,
    parameter int COMB_LEN_D    = COMB_LEN_D_DEF,
    parameter int ALLPASS_LEN_A = ALLPASS_LEN_A_DEF,
    parameter int ALLPASS_LEN_B = ALLPASS_LEN_B_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic signed [23:0] i_sample,
    input  logic               i_last,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic signed [23:0] o_sample,
    output logic               o_last
);

    localparam int CLEN [4] = '{COMB_LEN_A, COMB_LEN_B, COMB_LEN_C, COMB_LEN_D};
    localparam int ALEN [2] = '{ALLPASS_LEN_A, ALLPASS_LEN_B};
    localparam int CMAX01   = (COMB_LEN_A > COMB_LEN_B) ? COMB_LEN_A : COMB_LEN_B;
    localparam int CMAX23   = (COMB_LEN_C > COMB_LEN_D) ? COMB_LEN_C : COMB_LEN_D;
    localparam int CMAX     = (CMAX01 > CMAX23) ? CMAX01 : CMAX23;
    localparam int AMAX     = (ALLPASS_LEN_A > ALLPASS_LEN_B) ? ALLPASS_LEN_A
                                                              : ALLPASS_LEN_B;
    localparam int CLR_LEN  = (CMAX > AMAX) ? CMAX : AMAX;
    localparam int CW       = $clog2(CLR_LEN);

    // Configuration registers
    logic [15:0] r_gain, r_room, r_wet, r_d2;
    logic [14:0] r_d1;
    logic [33:0] w_d1_prod;

    assign w_d1_prod = {i_cfg_data, 1'b0} * RECIP5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RST;
            r_room <= ROOM_RST;
            r_wet  <= WET_RST;
            r_d1   <= D1_RST;
            r_d2   <= D2_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_GAIN: r_gain <= i_cfg_data;
                CFG_ROOM: r_room <= i_cfg_data;
                CFG_DAMP: begin
                    r_d1 <= w_d1_prod[32:18];
                    r_d2 <= UNITY - {1'b0, w_d1_prod[32:18]};
                end
                CFG_WET:  r_wet  <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    // Clearing sweep counter
    logic [CW-1:0] r_clr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr && (r_clr != CW'(CLR_LEN - 1))) begin
            r_clr <= r_clr + 1'b1;
        end
    end
    assign o_sts.clr_done = (r_clr == CW'(CLR_LEN - 1));

    // Input word latch
    logic signed [23:0] r_x;
    logic               r_last;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x    <= i_sample;
            r_last <= i_last;
        end
    end

    logic signed [23:0] r_cy [4];
    logic signed [23:0] r_ay [2];
    logic signed [23:0] r_lp [4];
    logic signed [25:0] r_scaled;
    logic signed [27:0] r_o;
    logic signed [46:0] r_prod, n_prod;

    // Shared multiplier with operand select and accumulate
    logic signed [27:0] m_a;
    logic        [16:0] m_b;
    logic signed [45:0] m_p;
    always_comb begin
        m_a = '0;
        m_b = '0;
        unique case (i_cmd.mop)
            MOP_X_GAIN:  begin m_a = 28'(r_x);               m_b = {1'b0, r_gain}; end
            MOP_Y_D2:    begin m_a = 28'(r_cy[i_cmd.comb_sel]); m_b = {1'b0, r_d2}; end
            MOP_LP_D1:   begin m_a = 28'(r_lp[i_cmd.comb_sel]); m_b = {2'b0, r_d1}; end
            MOP_LP_ROOM: begin m_a = 28'(r_lp[i_cmd.comb_sel]); m_b = {1'b0, r_room}; end
            MOP_O_WET:   begin m_a = r_o;                    m_b = {1'b0, r_wet}; end
            default:     ;
        endcase
        m_p    = 46'(m_a * $signed({1'b0, m_b}));
        n_prod = (i_cmd.mop == MOP_LP_D1) ? (r_prod + 47'(m_p)) : 47'(m_p);
    end

    logic signed [31:0] w_rnd;
    assign w_rnd = rnd15(r_prod);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mop != MOP_NONE) begin
            r_prod <= n_prod;
        end
        if (i_cmd.scale_ld) begin
            r_scaled <= 26'(w_rnd);
        end
    end

    // Lowpass stores
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_lp[i] <= '0;
            end
        end else if (i_cmd.lp_ld) begin
            r_lp[i_cmd.comb_sel] <= sat24(w_rnd);
        end
    end

    // Comb write value: scaled input plus rounded feedback
    logic signed [23:0] w_comb_wd;
    assign w_comb_wd = sat24(32'(r_scaled) + w_rnd);

    // Comb delay lines
    for (genvar g = 0; g < 4; g++) begin : g_comb
        localparam int L  = CLEN[g];
        localparam int AW = $clog2(L);
        logic signed [23:0] mem [L];
        logic [AW-1:0]      r_pos;
        logic               w_we, w_sel;
        logic [AW-1:0]      w_wa;
        logic signed [23:0] w_wd;

        assign w_sel = i_cmd.comb_wr && (i_cmd.comb_sel == 2'(g));
        assign w_we  = i_cmd.clr ? ({1'b0, r_clr} < (CW + 1)'(L)) : w_sel;
        assign w_wa  = i_cmd.clr ? r_clr[AW-1:0] : r_pos;
        assign w_wd  = i_cmd.clr ? '0 : w_comb_wd;

        always_ff @(posedge i_clk) begin
            if (w_we) begin
                mem[w_wa] <= w_wd;
            end
            if (i_cmd.rd) begin
                r_cy[g] <= mem[r_pos];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_pos <= '0;
            end else if (w_sel) begin
                r_pos <= (r_pos == AW'(L - 1)) ? '0 : r_pos + 1'b1;
            end
        end
    end

    // Allpass: input is the comb sum for the first stage, then the running output
    logic signed [25:0] w_sum;
    logic signed [27:0] w_ap_x;
    logic signed [23:0] w_ap_y, w_ap_wd;
    assign w_sum   = 26'(r_cy[0]) + 26'(r_cy[1]) + 26'(r_cy[2]) + 26'(r_cy[3]);
    assign w_ap_x  = i_cmd.ap_sel ? r_o : 28'(w_sum);
    assign w_ap_y  = r_ay[i_cmd.ap_sel];
    // y * 0.5 rounded half up is (y + 1) >> 1
    assign w_ap_wd = sat24(32'(w_ap_x) + 32'((25'(w_ap_y) + 25'sd1) >>> 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.ap_wr) begin
            r_o <= 28'(w_ap_y) - w_ap_x;
        end
    end

    for (genvar g = 0; g < 2; g++) begin : g_ap
        localparam int L  = ALEN[g];
        localparam int AW = $clog2(L);
        logic signed [23:0] mem [L];
        logic [AW-1:0]      r_pos;
        logic               w_we, w_sel;
        logic [AW-1:0]      w_wa;
        logic signed [23:0] w_wd;

        assign w_sel = i_cmd.ap_wr && (i_cmd.ap_sel == 1'(g));
        assign w_we  = i_cmd.clr ? ({1'b0, r_clr} < (CW + 1)'(L)) : w_sel;
        assign w_wa  = i_cmd.clr ? r_clr[AW-1:0] : r_pos;
        assign w_wd  = i_cmd.clr ? '0 : w_ap_wd;

        always_ff @(posedge i_clk) begin
            if (w_we) begin
                mem[w_wa] <= w_wd;
            end
            if (i_cmd.rd) begin
                r_ay[g] <= mem[r_pos];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_pos <= '0;
            end else if (w_sel) begin
                r_pos <= (r_pos == AW'(L - 1)) ? '0 : r_pos + 1'b1;
            end
        end
    end

    // Output register
    logic               r_ovalid;
    logic signed [23:0] r_osample;
    logic               r_olast;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_osample <= sat24(w_rnd);
            r_olast   <= r_last;
        end
    end

    assign o_sts.out_free = !r_ovalid || i_out_ready;
    assign o_out_valid    = r_ovalid;
    assign o_sample       = r_osample;
    assign o_last         = r_olast;

endmodule

[rtl/core/car_chk.sv]
// Port-level checks for the reverb core, bound to the top level.
module car_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [23:0] i_out_sample,
    input logic        i_out_last
);

    // A stalled output word stays valid and unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_sample)
            && $stable(i_out_last))
        else $error("output word changed while stalled");

    // One word at a time: no input taken right after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted on back-to-back cycles");

    // The clearing pass keeps input closed right after reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("input open during clearing pass");

    // A new output word appears only from the busy sequencer
    a_out_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("output word without work in flight");

endmodule

bind comb_allpass_reverb_core car_chk u_car_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_sample (o_out.sample_out),
    .i_out_last   (o_out.block_last_out)
);

[tb/comb_allpass_reverb_core_test.sv]
// Self-checking test of the comb/allpass reverb core: random bursts, output stalls, register sweeps.
module comb_allpass_reverb_core_test;
    import car_pkg::*;

    localparam int LAT_WAIT = 60;

    // Expected output word
    typedef struct {
        logic signed [23:0] smp;
        logic               last;
    } t_rev_word;

    // Behavioral reverb with its own state; queue of predicted output words
    class reverb_scoreboard;
        t_rev_word          pending[$];
        int                 errors;
        logic [15:0]        gain, room, damp, wet;
        logic signed [23:0] cline[4][2048];
        logic signed [23:0] aline[2][1024];
        logic signed [23:0] lp[4];
        int                 cpos[4];
        int                 apos[2];
        int                 clen[4];
        int                 alen[2];

        function new();
            gain = GAIN_RST; room = ROOM_RST; damp = 16'd16384; wet = WET_RST;
            clen = '{COMB_LEN_A_DEF, COMB_LEN_B_DEF, COMB_LEN_C_DEF, COMB_LEN_D_DEF};
            alen = '{ALLPASS_LEN_A_DEF, ALLPASS_LEN_B_DEF};
            errors = 0;
            for (int k = 0; k < 4; k++) begin
                lp[k] = '0; cpos[k] = 0;
                for (int j = 0; j < 2048; j++) cline[k][j] = '0;
            end
            for (int k = 0; k < 2; k++) begin
                apos[k] = 0;
                for (int j = 0; j < 1024; j++) aline[k][j] = '0;
            end
        endfunction

        function longint round_q15(longint p);
            return (p + 16384) >>> 15;
        endfunction

        function logic signed [23:0] clip24(longint v);
            if (v > 8388607) return 24'sh7FFFFF;
            if (v < -8388608) return 24'sh800000;
            return v[23:0];
        endfunction

        function void set_reg(t_cfg_idx idx, logic [15:0] val);
            case (idx)
                CFG_GAIN: gain = val;
                CFG_ROOM: room = val;
                CFG_DAMP: damp = val;
                CFG_WET:  wet = val;
            endcase
        endfunction

        // Note an accepted input word and predict its output
        function void note_input(logic signed [23:0] x, logic last);
            longint scaled, sum, o, y, d1, d2, nxt, lpv;
            t_rev_word w;
            d1 = (longint'(damp) * 2) / 5;
            d2 = 32768 - d1;
            scaled = round_q15(longint'(x) * longint'(gain));
            sum = 0;
            for (int k = 0; k < 4; k++) begin
                y = cline[k][cpos[k]];
                lpv = clip24(round_q15(y * d2 + longint'(lp[k]) * d1));
                lp[k] = lpv[23:0];
                cline[k][cpos[k]] = clip24(scaled + round_q15(lpv * longint'(room)));
                cpos[k] = (cpos[k] + 1 >= clen[k]) ? 0 : cpos[k] + 1;
                sum += y;
            end
            o = sum;
            for (int k = 0; k < 2; k++) begin
                y = aline[k][apos[k]];
                nxt = y - o;
                aline[k][apos[k]] = clip24(o + round_q15(y * 16384));
                apos[k] = (apos[k] + 1 >= alen[k]) ? 0 : apos[k] + 1;
                o = nxt;
            end
            w.smp = clip24(round_q15(o * longint'(wet)));
            w.last = last;
            pending.push_back(w);
        endfunction

        // Compare an accepted output word with the oldest prediction
        function void check_output(logic signed [23:0] smp, logic last);
            t_rev_word w;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word smp=%0d last=%0b", $time, smp, last);
                errors++;
                return;
            end
            w = pending.pop_front();
            if (smp !== w.smp) begin
                $display("%0t: sample expected %0d actual %0d", $time, w.smp, smp);
                errors++;
            end
            if (last !== w.last) begin
                $display("%0t: last expected %0b actual %0b", $time, w.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;
    bit          stall_on;

    car_in_if  in_ch();
    car_out_if out_ch();

    comb_allpass_reverb_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    reverb_scoreboard sb = new();

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #(64'd20 * 64'd1000000);
        $display("comb_allpass_reverb_core: mismatch");
        $finish;
    end

    // Output side: sample at rising edge, stall pattern changes at falling edge
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_output(out_ch.sample_out, out_ch.block_last_out);
    end

    int stall_phase = 0;
    always @(negedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (!stall_on) begin
            out_ch.ready <= 1'b1;
        end else begin
            // periodic stalls mixed with random ones
            out_ch.ready <= (stall_phase % 7 < 3) ? 1'b0 : ($urandom_range(0, 3) != 0);
        end
    end

    // Drive one word and hold it until accepted; valid is dropped by the idle tasks
    task automatic send_word(logic signed [23:0] smp, logic last);
        in_ch.valid <= 1'b1;
        in_ch.sample_in <= smp;
        in_ch.block_last_in <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_input(smp, last);
        @(negedge i_clk);
    endtask

    task automatic idle_cycles(int n);
        in_ch.valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (LAT_WAIT) @(negedge i_clk);
    endtask

    // One register write, with write enable dropped again before the task returns
    task automatic write_reg(t_cfg_idx idx, logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        sb.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic signed [23:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2: return 24'($urandom_range(0, 255)) - 24'd128;
            default: return 24'($urandom());
        endcase
    endfunction

    function automatic logic [15:0] rand_coef();
        case ($urandom_range(0, 4))
            0: return 16'd0;
            1: return 16'd32768;
            2: return 16'hFFFF;
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    // Random bursts of words with random gaps
    task automatic send_bursts(int count);
        int left, burst;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 40);
            if (burst > left) burst = left;
            repeat (burst) send_word(rand_sample(), $urandom_range(0, 7) == 0);
            left -= burst;
            if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 30));
        end
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.sample_in = '0;
        in_ch.block_last_in = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_GAIN;
        i_cfg_data = '0;
        stall_on = 1'b0;
        i_rst_n = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes with reset registers, then strong gains, then unity and zero settings
        send_word(24'sh7FFFFF, 1'b0);
        send_word(24'sh800000, 1'b1);
        send_word(24'sh000000, 1'b0);
        send_word(-24'sd1, 1'b1);
        send_word(24'sd1, 1'b0);
        drain();
        write_reg(CFG_GAIN, 16'hFFFF);
        write_reg(CFG_ROOM, 16'hFFFF);
        write_reg(CFG_DAMP, 16'hFFFF);
        write_reg(CFG_WET, 16'hFFFF);
        repeat (6) send_word(24'sh7FFFFF, 1'b0);
        repeat (6) send_word(24'sh800000, 1'b1);
        drain();
        write_reg(CFG_GAIN, 16'd32768);
        write_reg(CFG_ROOM, 16'd0);
        write_reg(CFG_DAMP, 16'd0);
        write_reg(CFG_WET, 16'd0);
        repeat (4) send_word(rand_sample(), 1'b1);
        drain();
        write_reg(CFG_WET, 16'd32768);
        write_reg(CFG_DAMP, 16'd32768);
        write_reg(CFG_ROOM, 16'd32768);
        repeat (4) send_word(rand_sample(), 1'b0);

        // Random phases: each with its own register setting and stall mode
        for (int ph = 0; ph < 8; ph++) begin
            drain();
            write_reg(CFG_GAIN, rand_coef());
            write_reg(CFG_ROOM, rand_coef());
            write_reg(CFG_DAMP, rand_coef());
            write_reg(CFG_WET, rand_coef());
            stall_on = (ph % 3 != 0);
            send_bursts(120);
            drain();  // sender holds off until everything is out
            send_bursts(120);
        end
        stall_on = 1'b0;
        drain();
        if (sb.errors == 0)
            $display("comb_allpass_reverb_core: match");
        else
            $display("comb_allpass_reverb_core: mismatch");
        $finish;
    end
endmodule
